// ===== rtl/log_record_ring_buffer_defines.svh =====
// Assertion macros shared by the log record ring buffer RTL.
`ifndef LOG_RECORD_RING_BUFFER_DEFINES_SVH
`define LOG_RECORD_RING_BUFFER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define LRRB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition at one edge is followed by another at the next edge.
`define LRRB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/lrrb_pkg.sv =====
// Types and constants of the log record ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package lrrb_pkg;

    localparam int META_BYTES   = 1;
    localparam int HDR_BYTES    = 4;
    localparam int LEAD_BYTES   = META_BYTES + HDR_BYTES;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 11;
    localparam int COUNT_OUT_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_NOTIFY_MODE      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTIFY_THRESHOLD = 1'd1;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_TEXT  = 3'd1,
        OP_DRAIN = 3'd2,
        OP_READ  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        NOTIFY_NEVER  = 2'd0,
        NOTIFY_ALWAYS = 2'd1,
        NOTIFY_ABOVE  = 2'd2
    } notify_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DROP_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPAN,
        ST_PUSH_HDR,
        ST_PUSH_TERM,
        ST_READ_DATA,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_ILLEGAL,
        CMD_SCAN_HEAD,
        CMD_SCAN_READ,
        CMD_SCAN_NEXT,
        CMD_DROP,
        CMD_PUSH_HDR,
        CMD_PUSH_TEXT,
        CMD_PUSH_TERM,
        CMD_DRAIN_ALL,
        CMD_DRAIN_ADD,
        CMD_DRAIN_END,
        CMD_READ_ISSUE,
        CMD_READ_POP,
        CMD_CLEAR,
        CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic busy;
        logic len_zero;
        logic text_bad;
        logic text_one;
        logic limit_zero;
        logic used_zero;
        logic limit_ge_used;
        logic need_drop;
        logic read_zero;
        logic hdr_last;
        logic scan_at_limit;
        logic rdata_zero;
        logic drain_fits;
        logic over_full;
        logic read_over;
        logic phase_clash;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/lrrb_in_if.sv =====
// Input channel of the log record ring buffer.
`timescale 1ns / 1ps
`default_nettype none
interface lrrb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  level;
    logic [31:0] timestamp;
    logic [7:0]  log_length;
    logic [7:0]  data_byte;
    logic [10:0] max_bytes;

    modport source (output valid, operation, level, timestamp, log_length, data_byte,
                    max_bytes, input ready);
    modport sink (input valid, operation, level, timestamp, log_length, data_byte,
                  max_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrrb_out_if.sv =====
// Result channel of the log record ring buffer.
`timescale 1ns / 1ps
`default_nettype none
interface lrrb_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] dropped_count;
    logic [10:0] copy_size;
    logic [7:0]  read_byte;
    logic        notify;
    logic [10:0] used_bytes;

    modport source (output valid, status, dropped_count, copy_size, read_byte, notify,
                    used_bytes, input ready);
    modport sink (input valid, status, dropped_count, copy_size, read_byte, notify,
                  used_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/log_record_ring_buffer.sv =====
// Top level of the log record ring buffer: sequencer, datapath and checks.
// One transfer in, one result out; items are handled one at a time.
// Text byte, read byte, clear and illegal items are decoded and finish without a record walk.
// Record start drops oldest records while room is short, scanning each for its terminator;
// drain scans bytes through the RAM read port and adds each whole record that fits.
// Reset clears pointers, counts and config; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "log_record_ring_buffer_defines.svh"
module log_record_ring_buffer #(
    parameter int BUFFER_BYTES     = 1024,
    parameter int MAX_RECORD_BYTES = 128
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lrrb_in_if.sink                               in_ch,
    lrrb_out_if.source                            out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [lrrb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lrrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    lrrb_pkg::ctrl_cmd_t  cmd;
    lrrb_pkg::dp_status_t dp_stat;

    // Sequencer: decode the latched item, walk records, hold the result
    // until the sink takes the transfer.
    lrrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (dp_stat),
        .cmd       (cmd)
    );

    // Datapath: ring pointers, byte store, drop count and result registers.
    lrrb_datapath #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (dp_stat),
        .operation     (in_ch.operation),
        .level         (in_ch.level),
        .timestamp     (in_ch.timestamp),
        .log_length    (in_ch.log_length),
        .data_byte     (in_ch.data_byte),
        .max_bytes     (in_ch.max_bytes),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (out_ch.status),
        .dropped_count (out_ch.dropped_count),
        .copy_size     (out_ch.copy_size),
        .read_byte     (out_ch.read_byte),
        .notify        (out_ch.notify),
        .used_bytes    (out_ch.used_bytes)
    );

    // An accepted item holds the input side until its result is produced.
    `LRRB_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken")
    // Fill level never passes capacity.
    `LRRB_ASSERT_ALWAYS(a_used_bound, !dp_stat.over_full, "used count above capacity")
    // Granted bytes never exceed what is stored.
    `LRRB_ASSERT_ALWAYS(a_grant_bound, !dp_stat.read_over, "grant above used count")
    // An open record and an unread grant never coexist.
    `LRRB_ASSERT_ALWAYS(a_phase, !dp_stat.phase_clash, "record open during grant")
endmodule
`default_nettype wire

// ===== rtl/lrrb_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/lrrb_ctrl.sv =====
// Sequencer of the log record ring buffer.
`timescale 1ns / 1ps
`default_nettype none
module lrrb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire lrrb_pkg::dp_status_t stat,
    output lrrb_pkg::ctrl_cmd_t      cmd
);
    lrrb_pkg::state_t state_reg, state_next;
    logic drain_reg, drain_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrrb_pkg::ST_IDLE;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        case (state_reg)
            lrrb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lrrb_pkg::ST_DECODE;
                end
            end
            lrrb_pkg::ST_DECODE:
            begin
                state_next = lrrb_pkg::ST_FINISH;
                case (stat.op)
                    lrrb_pkg::OP_START:
                    begin
                        if (!stat.busy && !stat.len_zero)
                        begin
                            state_next = lrrb_pkg::ST_DROP_CHK;
                            drain_next = 1'b0;
                        end
                    end
                    lrrb_pkg::OP_TEXT:
                    begin
                        if (!stat.text_bad && stat.text_one)
                        begin
                            state_next = lrrb_pkg::ST_PUSH_TERM;
                        end
                    end
                    lrrb_pkg::OP_DRAIN:
                    begin
                        if (!stat.busy && !stat.limit_zero && !stat.used_zero
                            && !stat.limit_ge_used)
                        begin
                            state_next = lrrb_pkg::ST_SCAN_RD;
                            drain_next = 1'b1;
                        end
                    end
                    lrrb_pkg::OP_READ:
                    begin
                        if (!stat.read_zero && !stat.used_zero)
                        begin
                            state_next = lrrb_pkg::ST_READ_DATA;
                        end
                    end
                    default:
                    begin
                        state_next = lrrb_pkg::ST_FINISH;
                    end
                endcase
            end
            lrrb_pkg::ST_DROP_CHK:
            begin
                state_next = stat.need_drop ? lrrb_pkg::ST_SCAN_RD : lrrb_pkg::ST_PUSH_HDR;
            end
            lrrb_pkg::ST_SCAN_RD:
            begin
                state_next = stat.scan_at_limit ? lrrb_pkg::ST_SPAN : lrrb_pkg::ST_SCAN_CHK;
            end
            lrrb_pkg::ST_SCAN_CHK:
            begin
                state_next = stat.rdata_zero ? lrrb_pkg::ST_SPAN : lrrb_pkg::ST_SCAN_RD;
            end
            lrrb_pkg::ST_SPAN:
            begin
                if (!drain_reg)
                begin
                    state_next = lrrb_pkg::ST_DROP_CHK;
                end
                else
                begin
                    state_next = stat.drain_fits ? lrrb_pkg::ST_SCAN_RD : lrrb_pkg::ST_FINISH;
                end
            end
            lrrb_pkg::ST_PUSH_HDR:
            begin
                if (stat.hdr_last)
                begin
                    state_next = lrrb_pkg::ST_FINISH;
                end
            end
            lrrb_pkg::ST_PUSH_TERM:
            begin
                state_next = lrrb_pkg::ST_FINISH;
            end
            lrrb_pkg::ST_READ_DATA:
            begin
                state_next = lrrb_pkg::ST_FINISH;
            end
            lrrb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lrrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op         = lrrb_pkg::CMD_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lrrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = lrrb_pkg::CMD_LATCH;
                end
            end
            lrrb_pkg::ST_DECODE:
            begin
                case (stat.op)
                    lrrb_pkg::OP_START:
                    begin
                        if (stat.busy)
                        begin
                            cmd.op = lrrb_pkg::CMD_ILLEGAL;
                        end
                    end
                    lrrb_pkg::OP_TEXT:
                    begin
                        cmd.op = stat.text_bad ? lrrb_pkg::CMD_ILLEGAL : lrrb_pkg::CMD_PUSH_TEXT;
                    end
                    lrrb_pkg::OP_DRAIN:
                    begin
                        if (stat.busy)
                        begin
                            cmd.op = lrrb_pkg::CMD_ILLEGAL;
                        end
                        else if (!stat.limit_zero && !stat.used_zero)
                        begin
                            cmd.op = stat.limit_ge_used ? lrrb_pkg::CMD_DRAIN_ALL
                                                        : lrrb_pkg::CMD_SCAN_HEAD;
                        end
                    end
                    lrrb_pkg::OP_READ:
                    begin
                        cmd.op = (stat.read_zero || stat.used_zero) ? lrrb_pkg::CMD_ILLEGAL
                                                                    : lrrb_pkg::CMD_READ_ISSUE;
                    end
                    lrrb_pkg::OP_CLEAR:
                    begin
                        cmd.op = lrrb_pkg::CMD_CLEAR;
                    end
                    default:
                    begin
                        cmd.op = lrrb_pkg::CMD_ILLEGAL;
                    end
                endcase
            end
            lrrb_pkg::ST_DROP_CHK:
            begin
                if (stat.need_drop)
                begin
                    cmd.op = lrrb_pkg::CMD_SCAN_HEAD;
                end
            end
            lrrb_pkg::ST_SCAN_RD:
            begin
                if (!stat.scan_at_limit)
                begin
                    cmd.op = lrrb_pkg::CMD_SCAN_READ;
                end
            end
            lrrb_pkg::ST_SCAN_CHK:
            begin
                if (!stat.rdata_zero)
                begin
                    cmd.op = lrrb_pkg::CMD_SCAN_NEXT;
                end
            end
            lrrb_pkg::ST_SPAN:
            begin
                if (!drain_reg)
                begin
                    cmd.op = lrrb_pkg::CMD_DROP;
                end
                else
                begin
                    cmd.op = stat.drain_fits ? lrrb_pkg::CMD_DRAIN_ADD : lrrb_pkg::CMD_DRAIN_END;
                end
            end
            lrrb_pkg::ST_PUSH_HDR:
            begin
                cmd.op = lrrb_pkg::CMD_PUSH_HDR;
            end
            lrrb_pkg::ST_PUSH_TERM:
            begin
                cmd.op = lrrb_pkg::CMD_PUSH_TERM;
            end
            lrrb_pkg::ST_READ_DATA:
            begin
                cmd.op = lrrb_pkg::CMD_READ_POP;
            end
            lrrb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op         = lrrb_pkg::CMD_EMIT;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd.op = lrrb_pkg::CMD_NONE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/lrrb_datapath.sv =====
// Pointers, counters, byte store and result registers of the ring buffer.
`timescale 1ns / 1ps
`default_nettype none
module lrrb_datapath #(
    parameter int BUFFER_BYTES     = 1024,
    parameter int MAX_RECORD_BYTES = 128
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lrrb_pkg::ctrl_cmd_t                 cmd,
    output lrrb_pkg::dp_status_t                     stat,
    input  wire logic [2:0]                          operation,
    input  wire logic [3:0]                          level,
    input  wire logic [31:0]                         timestamp,
    input  wire logic [7:0]                          log_length,
    input  wire logic [7:0]                          data_byte,
    input  wire logic [10:0]                         max_bytes,
    input  wire logic                                cfg_we,
    input  wire logic [lrrb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lrrb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     status,
    output logic [15:0]                              dropped_count,
    output logic [10:0]                              copy_size,
    output logic [7:0]                               read_byte,
    output logic                                     notify,
    output logic [10:0]                              used_bytes
);
    localparam int AW         = $clog2(BUFFER_BYTES);
    localparam int CW         = $clog2(BUFFER_BYTES + 1);
    localparam int GW         = CW + 3;
    localparam int SUMW       = AW + 2;
    localparam int SCAN_LIMIT = MAX_RECORD_BYTES - lrrb_pkg::LEAD_BYTES;
    localparam int IW         = $clog2(SCAN_LIMIT + 1);
    localparam int SW         = $clog2(MAX_RECORD_BYTES + 2);

    function automatic logic [AW-1:0] wrap(input logic [SUMW-1:0] s);
        logic [SUMW-1:0] r;
        r = (s >= SUMW'(BUFFER_BYTES)) ? s - SUMW'(BUFFER_BYTES) : s;
        return r[AW-1:0];
    endfunction

    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] base_reg, base_next, scan_pos_reg, scan_pos_next;
    logic [CW-1:0] used_reg, used_next, read_rem_reg, read_rem_next, copy_reg, copy_next;
    logic [15:0]   drop_reg, drop_next;
    logic [7:0]    text_rem_reg, text_rem_next;
    logic [IW-1:0] scan_i_reg, scan_i_next;
    logic [2:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]    mode_reg;
    logic [10:0]   thr_reg;
    logic          status_reg, status_next, note_reg, note_next;
    logic [7:0]    rbyte_reg, rbyte_next;

    lrrb_pkg::op_t op_reg;
    logic [3:0]    level_reg;
    logic [31:0]   ts_reg;
    logic [7:0]    len_reg, dbyte_reg;
    logic [10:0]   limit_reg;

    logic          o_status_reg, o_note_reg;
    logic [15:0]   o_drop_reg;
    logic [10:0]   o_copy_reg, o_used_reg;
    logic [7:0]    o_rbyte_reg;

    logic          ram_we;
    logic [7:0]    ram_wdata, ram_rdata, hdr_byte, tlen;
    logic [AW-1:0] ram_raddr, nb_addr;
    logic [SW-1:0] span;
    logic [GW-1:0] used_g, copy_g, span_g, limit_g, drain_sum, used_inc_g, copy_g_out;

    lrrb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Text length capped to what one record may carry.
    assign tlen = ({1'b0, len_reg} >= 9'(SCAN_LIMIT)) ? 8'(SCAN_LIMIT - 1) : len_reg;
    assign span = SW'(scan_i_reg) + SW'(lrrb_pkg::LEAD_BYTES + 1);

    assign used_g     = GW'(used_reg);
    assign copy_g     = GW'(copy_reg);
    assign span_g     = GW'(span);
    assign limit_g    = GW'(limit_reg);
    assign drain_sum  = copy_g + span_g;
    assign used_inc_g = used_g + GW'(1);
    assign nb_addr    = wrap(SUMW'(base_reg) + SUMW'(span));
    assign ram_raddr  = (cmd.op == lrrb_pkg::CMD_SCAN_READ) ? scan_pos_reg : head_reg;

    always_comb
    begin
        case (hdr_cnt_reg)
            3'd0:    hdr_byte = {4'd0, level_reg};
            3'd1:    hdr_byte = ts_reg[7:0];
            3'd2:    hdr_byte = ts_reg[15:8];
            3'd3:    hdr_byte = ts_reg[23:16];
            3'd4:    hdr_byte = ts_reg[31:24];
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        stat.op            = op_reg;
        stat.busy          = (text_rem_reg != 8'd0) || (read_rem_reg != '0);
        stat.len_zero      = (len_reg == 8'd0);
        stat.text_bad      = (text_rem_reg == 8'd0) || (dbyte_reg == 8'd0);
        stat.text_one      = (text_rem_reg == 8'd1);
        stat.limit_zero    = (limit_reg == 11'd0);
        stat.used_zero     = (used_reg == '0);
        stat.limit_ge_used = (limit_g >= used_g);
        stat.need_drop     = (used_g + GW'(tlen) + GW'(lrrb_pkg::LEAD_BYTES + 1))
                             > GW'(BUFFER_BYTES);
        stat.read_zero     = (read_rem_reg == '0);
        stat.hdr_last      = (hdr_cnt_reg == 3'(lrrb_pkg::HDR_BYTES));
        stat.scan_at_limit = (scan_i_reg == IW'(SCAN_LIMIT));
        stat.rdata_zero    = (ram_rdata == 8'd0);
        stat.drain_fits    = (drain_sum <= limit_g) && (drain_sum <= used_g);
        stat.over_full     = (used_g > GW'(BUFFER_BYTES));
        stat.read_over     = (GW'(read_rem_reg) > used_g);
        stat.phase_clash   = (text_rem_reg != 8'd0) && (read_rem_reg != '0);
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        base_next     = base_reg;
        scan_pos_next = scan_pos_reg;
        used_next     = used_reg;
        read_rem_next = read_rem_reg;
        copy_next     = copy_reg;
        drop_next     = drop_reg;
        text_rem_next = text_rem_reg;
        scan_i_next   = scan_i_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        status_next   = status_reg;
        note_next     = note_reg;
        rbyte_next    = rbyte_reg;
        ram_we        = 1'b0;
        ram_wdata     = 8'd0;
        case (cmd.op)
            lrrb_pkg::CMD_LATCH:
            begin
                status_next  = 1'b0;
                note_next    = 1'b0;
                rbyte_next   = 8'd0;
                copy_next    = '0;
                hdr_cnt_next = 3'd0;
            end
            lrrb_pkg::CMD_ILLEGAL:
            begin
                status_next = 1'b1;
            end
            lrrb_pkg::CMD_SCAN_HEAD:
            begin
                base_next     = head_reg;
                scan_pos_next = wrap(SUMW'(head_reg) + SUMW'(lrrb_pkg::LEAD_BYTES));
                scan_i_next   = '0;
            end
            lrrb_pkg::CMD_SCAN_NEXT:
            begin
                scan_pos_next = wrap(SUMW'(scan_pos_reg) + SUMW'(1));
                scan_i_next   = scan_i_reg + IW'(1);
            end
            lrrb_pkg::CMD_DROP:
            begin
                if (drop_reg != 16'hFFFF)
                begin
                    drop_next = drop_reg + 16'd1;
                end
                if (span_g >= used_g)
                begin
                    head_next = tail_reg;
                    used_next = '0;
                end
                else
                begin
                    head_next = wrap(SUMW'(head_reg) + SUMW'(span));
                    used_next = used_reg - CW'(span);
                end
            end
            lrrb_pkg::CMD_PUSH_HDR:
            begin
                ram_we    = 1'b1;
                ram_wdata = hdr_byte;
                tail_next = wrap(SUMW'(tail_reg) + SUMW'(1));
                used_next = used_reg + CW'(1);
                if (hdr_cnt_reg == 3'(lrrb_pkg::HDR_BYTES))
                begin
                    hdr_cnt_next  = 3'd0;
                    text_rem_next = tlen;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end
            end
            lrrb_pkg::CMD_PUSH_TEXT:
            begin
                ram_we        = 1'b1;
                ram_wdata     = dbyte_reg;
                tail_next     = wrap(SUMW'(tail_reg) + SUMW'(1));
                used_next     = used_reg + CW'(1);
                text_rem_next = text_rem_reg - 8'd1;
            end
            lrrb_pkg::CMD_PUSH_TERM:
            begin
                ram_we    = 1'b1;
                ram_wdata = 8'd0;
                tail_next = wrap(SUMW'(tail_reg) + SUMW'(1));
                used_next = used_reg + CW'(1);
                note_next = (mode_reg == lrrb_pkg::NOTIFY_ALWAYS)
                         || ((mode_reg == lrrb_pkg::NOTIFY_ABOVE)
                             && (used_inc_g > GW'(thr_reg)));
            end
            lrrb_pkg::CMD_DRAIN_ALL:
            begin
                copy_next     = used_reg;
                read_rem_next = used_reg;
            end
            lrrb_pkg::CMD_DRAIN_ADD:
            begin
                copy_next     = copy_reg + CW'(span);
                base_next     = nb_addr;
                scan_pos_next = wrap(SUMW'(nb_addr) + SUMW'(lrrb_pkg::LEAD_BYTES));
                scan_i_next   = '0;
            end
            lrrb_pkg::CMD_DRAIN_END:
            begin
                read_rem_next = copy_reg;
            end
            lrrb_pkg::CMD_READ_POP:
            begin
                rbyte_next    = ram_rdata;
                head_next     = wrap(SUMW'(head_reg) + SUMW'(1));
                used_next     = used_reg - CW'(1);
                read_rem_next = read_rem_reg - CW'(1);
            end
            lrrb_pkg::CMD_CLEAR:
            begin
                head_next     = '0;
                tail_next     = '0;
                used_next     = '0;
                drop_next     = 16'd0;
                text_rem_next = 8'd0;
                read_rem_next = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            used_reg     <= '0;
            read_rem_reg <= '0;
            drop_reg     <= 16'd0;
            text_rem_reg <= 8'd0;
            hdr_cnt_reg  <= 3'd0;
            mode_reg     <= lrrb_pkg::NOTIFY_NEVER;
            thr_reg      <= 11'd0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            used_reg     <= used_next;
            read_rem_reg <= read_rem_next;
            drop_reg     <= drop_next;
            text_rem_reg <= text_rem_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            if (cfg_we && (cfg_index == lrrb_pkg::CFG_NOTIFY_MODE))
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_we && (cfg_index == lrrb_pkg::CFG_NOTIFY_THRESHOLD))
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    assign copy_g_out = GW'(copy_reg);

    // Working and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        scan_pos_reg <= scan_pos_next;
        scan_i_reg   <= scan_i_next;
        copy_reg     <= copy_next;
        status_reg   <= status_next;
        note_reg     <= note_next;
        rbyte_reg    <= rbyte_next;
        if (cmd.op == lrrb_pkg::CMD_LATCH)
        begin
            op_reg    <= lrrb_pkg::op_t'(operation);
            level_reg <= level;
            ts_reg    <= timestamp;
            len_reg   <= log_length;
            dbyte_reg <= data_byte;
            limit_reg <= max_bytes;
        end
        if (cmd.op == lrrb_pkg::CMD_EMIT)
        begin
            o_status_reg <= status_reg;
            o_note_reg   <= note_reg;
            o_drop_reg   <= drop_reg;
            o_copy_reg   <= copy_g_out[10:0];
            o_used_reg   <= used_g[10:0];
            o_rbyte_reg  <= rbyte_reg;
        end
    end

    assign status        = o_status_reg;
    assign dropped_count = o_drop_reg;
    assign copy_size     = o_copy_reg;
    assign read_byte     = o_rbyte_reg;
    assign notify        = o_note_reg;
    assign used_bytes    = o_used_reg;
endmodule
`default_nettype wire
